### design/i2c_eeprom_master_macros.svh
// Assertion macros for the I2C EEPROM master.
// Included by the modules that check their own logic.
`ifndef I2C_EEPROM_MASTER_MACROS_SVH
`define I2C_EEPROM_MASTER_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("%m: label");
`define ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("%m: label");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

### design/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C EEPROM master.
// No dependencies.
package i2cm_pkg;
    localparam int PHASE_COUNT_BITS_DEF = 16;
    localparam logic [6:0] DEV_ADDR_RESET = 7'd80;
    localparam logic [15:0] TPP_RESET = 16'd1;
    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_TPP = 1'b1;
    localparam logic [7:0] CTRL_W_MASK = 8'hfe;

    typedef struct packed {
        logic       op;
        logic       is_read;
        logic       first_byte;
        logic       last_byte;
        logic [15:0] mem_addr;
        logic [7:0] wdata;
        logic       scl_in;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic [7:0] rdata;
        logic       rdata_valid;
        logic       ready_res;
        logic       bus_busy_error;
        logic       transfer_done;
    } result_t;
endpackage

### design/i2cm_front.sv
`timescale 1ns / 1ps
// Input side: skid queue of two entries that accepts and holds items.
// Depends on i2cm_pkg.
module i2cm_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  i2cm_pkg::item_t in_item,
    output logic            q_valid,
    input  logic            q_ready,
    output i2cm_pkg::item_t q_item
);
    import i2cm_pkg::*;
    item_t mem_reg [2];
    logic  wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;
    assign in_ready = cnt_reg != 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_item = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = q_valid && q_ready;
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_item;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
`include "i2c_eeprom_master_macros.svh"
    `ASSERT_NEVER(a_no_overflow, aclk, aresetn, cnt_reg == 2'd3)
    `ASSERT_IMPL(a_count_up, aclk, aresetn, (push && !pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
    `ASSERT_IMPL(a_pop_nonempty, aclk, aresetn, pop |-> cnt_reg != 2'd0)
endmodule

### design/i2cm_back.sv
`timescale 1ns / 1ps
// Sequencer: runs one queued item per cycle into an output register, stalled while that holds an unread result.
// Depends on i2cm_pkg.
module i2cm_back #(
    parameter int PHASE_COUNT_BITS = i2cm_pkg::PHASE_COUNT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  i2cm_pkg::item_t   q_item,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata,
    output logic              out_valid,
    input  logic              out_ready,
    output i2cm_pkg::result_t out_res
);
    import i2cm_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_FREE = 4'd1, S_START = 4'd2, S_CTRLW = 4'd3,
        S_ADDRH = 4'd4, S_ADDRL = 4'd5, S_DATA = 4'd6, S_WAIT = 4'd7, S_RSTART = 4'd8,
        S_CTRLR = 4'd9, S_RX = 4'd10, S_STOP = 4'd11;
    localparam int PCW = PHASE_COUNT_BITS;
    localparam int CW = (PCW > 16) ? PCW : 16;

    logic [6:0] dev_reg;
    logic [15:0] tpp_reg;
    logic [3:0] st_reg, st_next;
    logic [PCW-1:0] pc_reg, pc_next, pc_inc;
    logic [1:0] qp_reg, qp_next;
    logic [3:0] bc_reg, bc_next;
    logic [7:0] sh_reg, sh_next;
    logic [15:0] al_reg, al_next;
    logic rm_reg, rm_next, fp_reg, fp_next;
    logic ov_reg;
    result_t res_reg, res_next;
    logic take, step, is_tx, clk_hi;
    logic [7:0] txv;
    logic [1:0] q;

    assign q_ready = !ov_reg || out_ready;
    assign take = q_valid && q_ready;
    assign out_valid = ov_reg;
    assign out_res = res_reg;
    assign pc_inc = pc_reg + {{(PCW-1){1'b0}}, 1'b1};
    assign is_tx = st_reg == S_CTRLW || st_reg == S_ADDRH || st_reg == S_ADDRL ||
                   st_reg == S_DATA || st_reg == S_CTRLR;

    always_comb begin
        st_next = st_reg; pc_next = pc_reg; qp_next = qp_reg; bc_next = bc_reg;
        sh_next = sh_reg; al_next = al_reg; rm_next = rm_reg; fp_next = fp_reg;
        res_next = '0;
        step = 1'b0;
        q = qp_reg;
        if (q_item.op) begin
            if (st_reg == S_IDLE && q_item.first_byte) begin
                rm_next = q_item.is_read; al_next = q_item.mem_addr;
                sh_next = q_item.wdata; fp_next = q_item.last_byte;
                st_next = S_FREE; qp_next = '0; bc_next = '0; pc_next = '0;
            end else if (st_reg == S_WAIT && !q_item.first_byte) begin
                fp_next = q_item.last_byte;
                sh_next = rm_reg ? 8'h00 : q_item.wdata;
                st_next = rm_reg ? S_RX : S_DATA;
                qp_next = '0; bc_next = '0; pc_next = '0;
            end
        end else if (st_reg != S_IDLE && st_reg != S_WAIT) begin
            if (pc_inc == '0 || CW'(pc_inc) >= CW'(tpp_reg)) begin
                pc_next = '0;
                step = 1'b1;
            end else begin
                pc_next = pc_inc;
            end
        end
        if (step) begin
            case (st_reg)
                S_FREE: begin
                    if (q == 2'd0) qp_next = 2'd1;
                    else begin
                        st_next = (q_item.scl_in && q_item.sda_in) ? S_START : S_IDLE;
                        res_next.bus_busy_error = !(q_item.scl_in && q_item.sda_in);
                        qp_next = '0; bc_next = '0;
                    end
                end
                S_START: begin
                    if (q >= 2'd2) begin st_next = S_CTRLW; qp_next = '0; bc_next = '0; end
                    else qp_next = q + 2'd1;
                end
                S_RSTART: begin
                    if (q == 2'd3) begin st_next = S_CTRLR; qp_next = '0; bc_next = '0; end
                    else qp_next = q + 2'd1;
                end
                S_STOP: begin
                    if (q == 2'd3) begin
                        st_next = S_IDLE; qp_next = '0; bc_next = '0;
                        res_next.transfer_done = 1'b1;
                    end else qp_next = q + 2'd1;
                end
                S_RX: begin
                    if (bc_reg < 4'd8 && q == 2'd2) sh_next = {sh_reg[6:0], q_item.sda_in};
                    if (q != 2'd3) qp_next = q + 2'd1;
                    else if (bc_reg < 4'd8) begin
                        bc_next = bc_reg + 4'd1; qp_next = '0;
                        if (bc_reg == 4'd7) begin
                            res_next.rdata = sh_reg;
                            res_next.rdata_valid = 1'b1;
                        end
                    end else begin
                        st_next = fp_reg ? S_STOP : S_WAIT; qp_next = '0; bc_next = '0;
                    end
                end
                default: begin
                    if (is_tx) begin
                        if (bc_reg >= 4'd8 && q == 2'd2 && q_item.sda_in) begin
                            // hold for ACK
                        end else if (q != 2'd3) qp_next = q + 2'd1;
                        else if (bc_reg < 4'd8) begin
                            bc_next = bc_reg + 4'd1; qp_next = '0;
                        end else begin
                            qp_next = '0; bc_next = '0;
                            case (st_reg)
                                S_CTRLW: st_next = S_ADDRH;
                                S_ADDRH: st_next = S_ADDRL;
                                S_ADDRL: st_next = rm_reg ? S_RSTART : S_DATA;
                                S_CTRLR: begin sh_next = 8'h00; st_next = S_RX; end
                                default: st_next = fp_reg ? S_STOP : S_WAIT;
                            endcase
                        end
                    end else begin
                        st_next = S_IDLE; qp_next = '0; bc_next = '0;
                    end
                end
            endcase
        end
        // line drives from the next state
        clk_hi = qp_next == 2'd1 || qp_next == 2'd2;
        case (st_next)
            S_CTRLW: txv = {dev_reg, 1'b0} & CTRL_W_MASK;
            S_CTRLR: txv = ({dev_reg, 1'b0} & CTRL_W_MASK) | 8'h01;
            S_ADDRH: txv = al_next[15:8];
            S_ADDRL: txv = al_next[7:0];
            default: txv = sh_next;
        endcase
        res_next.scl_drive = 1'b1;
        res_next.sda_drive = 1'b1;
        case (st_next)
            S_START: begin
                res_next.scl_drive = qp_next <= 2'd1;
                res_next.sda_drive = qp_next == 2'd0;
            end
            S_RSTART: begin
                res_next.scl_drive = clk_hi;
                res_next.sda_drive = qp_next <= 2'd1;
            end
            S_WAIT: res_next.scl_drive = 1'b0;
            S_RX: begin
                res_next.scl_drive = clk_hi;
                if (bc_next >= 4'd8) res_next.sda_drive = fp_next;
            end
            S_STOP: begin
                res_next.scl_drive = qp_next >= 2'd2;
                res_next.sda_drive = qp_next == 2'd0 || qp_next == 2'd3;
            end
            S_CTRLW, S_CTRLR, S_ADDRH, S_ADDRL, S_DATA: begin
                res_next.scl_drive = clk_hi;
                res_next.sda_drive = (bc_next < 4'd8) ? txv[3'd7 - bc_next[2:0]] : 1'b1;
            end
            default: ;
        endcase
        res_next.ready_res = st_next == S_IDLE || st_next == S_WAIT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_reg <= DEV_ADDR_RESET;
            tpp_reg <= TPP_RESET;
            st_reg <= S_IDLE;
            ov_reg <= 1'b0;
            pc_reg <= '0; qp_reg <= '0; bc_reg <= '0; sh_reg <= '0;
            al_reg <= '0; rm_reg <= 1'b0; fp_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_DEV_ADDR) dev_reg <= cfg_wdata[6:0];
            if (cfg_we && cfg_index == CFG_TPP) tpp_reg <= cfg_wdata;
            if (take) begin
                st_reg <= st_next;
                res_reg <= res_next;
                pc_reg <= pc_next; qp_reg <= qp_next; bc_reg <= bc_next;
                sh_reg <= sh_next; al_reg <= al_next; rm_reg <= rm_next; fp_reg <= fp_next;
            end
            if (take) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end
`include "i2c_eeprom_master_macros.svh"
    `ASSERT_NEVER(a_bad_state, aclk, aresetn, st_reg > S_STOP)
    `ASSERT_NEVER(a_bitcnt, aclk, aresetn, bc_reg > 4'd8)
    `ASSERT_IMPL(a_hold_out, aclk, aresetn, (ov_reg && !out_ready) |=> $stable(res_reg))
endmodule

### design/i2c_eeprom_master.sv
`timescale 1ns / 1ps
// I2C EEPROM master, 16-bit memory address, sequential read and write.
// Every input item (tick or byte request) gives exactly one result,
// registered in the queue entry, then in the sequencer; one item is taken
// per clock while no result waits unread, by the phase sequencer behind a
// two-entry input queue. Results sit in an output register; while a
// result waits, the queue takes up to two more items, then the input stalls.
// Config index 0 is the device address, index 1 the ticks per quarter-bit
// phase; write only while idle.
module i2c_eeprom_master #(
    parameter int PHASE_COUNT_BITS = i2cm_pkg::PHASE_COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic        s_is_read,
    input  logic        s_first_byte,
    input  logic        s_last_byte,
    input  logic [15:0] s_mem_addr,
    input  logic [7:0]  s_wdata,
    input  logic        s_scl_in,
    input  logic        s_sda_in,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_drive,
    output logic        m_sda_drive,
    output logic [7:0]  m_rdata,
    output logic        m_rdata_valid,
    output logic        m_ready_res,
    output logic        m_bus_busy_error,
    output logic        m_transfer_done
);
    import i2cm_pkg::*;
    item_t in_item, q_item;
    result_t res;
    logic q_valid, q_ready;
    assign in_item = '{op: s_op, is_read: s_is_read, first_byte: s_first_byte,
        last_byte: s_last_byte, mem_addr: s_mem_addr, wdata: s_wdata,
        scl_in: s_scl_in, sda_in: s_sda_in};
    i2cm_front u_front (.aclk, .aresetn, .in_valid(s_valid), .in_ready(s_ready),
        .in_item, .q_valid, .q_ready, .q_item);
    i2cm_back #(.PHASE_COUNT_BITS(PHASE_COUNT_BITS)) u_back (.aclk, .aresetn,
        .q_valid, .q_ready, .q_item, .cfg_we, .cfg_index, .cfg_wdata,
        .out_valid(m_valid), .out_ready(m_ready), .out_res(res));
    assign m_scl_drive = res.scl_drive;
    assign m_sda_drive = res.sda_drive;
    assign m_rdata = res.rdata;
    assign m_rdata_valid = res.rdata_valid;
    assign m_ready_res = res.ready_res;
    assign m_bus_busy_error = res.bus_busy_error;
    assign m_transfer_done = res.transfer_done;
endmodule
